### design/frame_crc16_check_assert.svh
// Assertion macros for the frame CRC-16 check block.
// Used by the port checker; no other dependencies.
`ifndef FRAME_CRC16_CHECK_ASSERT_SVH
`define FRAME_CRC16_CHECK_ASSERT_SVH

// Same-cycle implication.
`define FCRC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("frame_crc16_check: assertion failed");

// Next-cycle implication.
`define FCRC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("frame_crc16_check: assertion failed");

`endif

### design/fcrc_pkg.sv
// Types, register map and CRC byte update for the frame CRC-16 check.
// No dependencies.
package fcrc_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr[2]
   localparam logic [0:0] REG_CRC_SEED         = 1'b0;
   localparam logic [0:0] REG_CRC_FIELD_OFFSET = 1'b1;

   localparam logic [15:0] CRC_POLY       = 16'h1021;
   localparam logic [15:0] CRC_SEED_RESET = 16'hFFFF;
   localparam logic [7:0]  CRC_OFS_RESET  = 8'h00;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } fcrc_req_type;

   typedef struct packed {
      logic [15:0] crc_value;
      logic        crc_match;
   } fcrc_rsp_type;

   typedef struct packed {
      logic [15:0] crc_seed;
      logic [7:0]  crc_field_offset;
   } fcrc_cfg_type;

   // CRC-16/CCITT-FALSE, one byte, MSB first
   function automatic logic [15:0] fcrc_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] v;
      v = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (v[15]) begin
            v = {v[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            v = {v[14:0], 1'b0};
         end
      end
      return v;
   endfunction

endpackage

### design/fcrc_csr.sv
// APB-style register file for the frame CRC-16 check (seed, field offset).
// Depends on fcrc_pkg.
module fcrc_csr
   import fcrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output fcrc_cfg_type          cfg
);

   logic [15:0] seed_ff;
   logic [7:0]  ofs_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= CRC_SEED_RESET;
         ofs_ff  <= CRC_OFS_RESET;
      end else if (wr_en) begin
         unique case (paddr[2])
            REG_CRC_SEED:         seed_ff <= pwdata[15:0];
            REG_CRC_FIELD_OFFSET: ofs_ff  <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_CRC_SEED:         prdata = {16'h0000, seed_ff};
         REG_CRC_FIELD_OFFSET: prdata = {24'h000000, ofs_ff};
         default:              prdata = '0;
      endcase
   end

   assign cfg.crc_seed         = seed_ff;
   assign cfg.crc_field_offset = ofs_ff;

endmodule

### design/frame_crc16_check.sv
// Frame CRC-16/CCITT-FALSE checker, top level.
// Depends on fcrc_pkg and fcrc_csr.
//
// Streams one frame a byte per word on the req channel, last byte flagged.
// The CRC (poly 0x1021, MSB first, no reflection, no final xor) starts from
// the crc_seed register, sampled when the first byte of a frame arrives, so
// a seed write takes effect from the next frame start. The two bytes at
// crc_field_offset and offset+1 enter the CRC as zero and are captured
// little-endian as the stored CRC. On the last byte one rsp word carries the
// computed CRC and a match flag; the block then starts a fresh frame. Rate is
// one byte per clock: the eight-bit CRC update is combinational XOR logic
// between the frame state registers and the result register. A result shows
// on rsp in the cycle after its last byte is taken. req_ready drops only while a
// result sits in the output register and rsp_ready is low. The byte position
// saturates at MAX_FRAME_BYTES; bytes at or past it are never treated as CRC
// field bytes. Registers: 0x0 crc_seed (16 bits, reset 0xFFFF), 0x4
// crc_field_offset (8 bits, reset 0); write only while no frame is in flight.
module frame_crc16_check
   import fcrc_pkg::*;
#(
   parameter int MAX_FRAME_BYTES = 1024
)(
   input  logic                  clock,
   input  logic                  reset,
   // byte stream
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fcrc_req_type          req_data,
   // results
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fcrc_rsp_type          rsp_data,
   // configuration
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // position counter holds 0..MAX_FRAME_BYTES
   localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
   // compare width covers both the counter and offset+1
   localparam int CMP_W = (POS_W > 9) ? POS_W : 9;

   fcrc_cfg_type cfg;

   fcrc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // frame state
   logic [15:0]      crc_ff,    crc_in;
   logic [POS_W-1:0] pos_ff,    pos_in;
   logic [15:0]      stored_ff, stored_in;
   // result register
   logic             rsp_valid_ff, rsp_valid_in;
   fcrc_rsp_type     rsp_ff,       rsp_in;

   logic             req_fire;
   logic             pos_live;
   logic [CMP_W-1:0] pos_ext, lo_ext, hi_ext;
   logic             hit_lo, hit_hi;
   logic [15:0]      crc_start, crc_next, stored_next;
   logic [7:0]       fed_byte;

   // output register frees when empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign pos_live = pos_ff < POS_W'(MAX_FRAME_BYTES);
   assign pos_ext  = CMP_W'(pos_ff);
   assign lo_ext   = CMP_W'(cfg.crc_field_offset);
   assign hi_ext   = lo_ext + CMP_W'(1);
   assign hit_lo   = pos_live && (pos_ext == lo_ext);
   assign hit_hi   = pos_live && !hit_lo && (pos_ext == hi_ext);

   // seed sampled at frame start
   assign crc_start = (pos_ff == '0) ? cfg.crc_seed : crc_ff;
   assign fed_byte  = (hit_lo || hit_hi) ? 8'h00 : req_data.data_byte;
   assign crc_next  = fcrc_byte(crc_start, fed_byte);

   // CRC field captured low byte first
   always_comb begin
      priority if (hit_lo) begin
         stored_next = {stored_ff[15:8], req_data.data_byte};
      end else if (hit_hi) begin
         stored_next = {req_data.data_byte, stored_ff[7:0]};
      end else begin
         stored_next = stored_ff;
      end
   end

   always_comb begin
      crc_in       = crc_ff;
      pos_in       = pos_ff;
      stored_in    = stored_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_fire) begin
         if (req_data.last_byte) begin
            // close the frame, restart at position zero
            crc_in           = cfg.crc_seed;
            pos_in           = '0;
            stored_in        = '0;
            rsp_in.crc_value = crc_next;
            rsp_in.crc_match = (crc_next == stored_next);
            rsp_valid_in     = 1'b1;
         end else begin
            crc_in    = crc_next;
            stored_in = stored_next;
            pos_in    = pos_live ? pos_ff + POS_W'(1) : pos_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         stored_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         stored_ff    <= stored_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset needed (position zero selects the seed)
   always_ff @(posedge clock) begin
      crc_ff <= crc_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/fcrc_checker.sv
// Port-level checker for frame_crc16_check, bound to the top level.
// Depends on fcrc_pkg and frame_crc16_check_assert.svh.
`include "frame_crc16_check_assert.svh"

module fcrc_checker
   import fcrc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input fcrc_req_type          req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input fcrc_rsp_type          rsp_data,
   input logic                  csr_pready
);

   logic req_fire;
   logic last_fire;
   logic rsp_stall;

   assign req_fire  = req_valid && req_ready;
   assign last_fire = req_fire && req_data.last_byte;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // a stalled result holds
   `FCRC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))

   // with the output register empty the stream is never held off
   `FCRC_ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // a new result only follows an accepted last byte
   `FCRC_ASSERT_IMP(a_rsp_from_last, clock, reset, $rose(rsp_valid), $past(last_fire))

   // a non-final word never produces a result
   `FCRC_ASSERT_NXT(a_no_rsp_mid_frame, clock, reset, req_fire && !req_data.last_byte, !rsp_valid)

   // register port never waits
   `FCRC_ASSERT_IMP(a_pready, clock, reset, 1'b1, csr_pready)

endmodule

bind frame_crc16_check fcrc_checker u_fcrc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_data   (req_data),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_data   (rsp_data),
   .csr_pready (csr_pready)
);
